[src/assert_macros.svh]
// Assertion macros used by the RTL module miller_rabin_primality_test.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AST_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// The condition must hold in every cycle out of reset.
`define AST_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("assertion failed");

`endif

[src/mrpt_pkg.sv]
// Package for the Miller-Rabin primality tester: widths, bases, state type.
// Used by mrpt_mulmod and miller_rabin_primality_test; depends on nothing.
`default_nettype none
package mrpt_pkg;
	localparam int VALUE_WIDTH = 64;
	localparam int BASE_COUNT  = 12;
	localparam int CNT_W       = $clog2(VALUE_WIDTH);
	localparam int RND_W       = $clog2(VALUE_WIDTH) + 1;
	localparam int IDX_W       = $clog2(BASE_COUNT);

	typedef logic [VALUE_WIDTH-1:0] value_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECOMP,
		ST_BASE,
		ST_REDUCE,
		ST_POW,
		ST_POW_MUL,
		ST_POW_SQ,
		ST_CHECK,
		ST_SQ_LOOP,
		ST_SQ_WAIT,
		ST_DONE
	} state_t;

	function automatic value_t base_of(input logic [IDX_W-1:0] k);
		logic [5:0] b;
		case (k)
			4'd0:    b = 6'd2;
			4'd1:    b = 6'd3;
			4'd2:    b = 6'd5;
			4'd3:    b = 6'd7;
			4'd4:    b = 6'd11;
			4'd5:    b = 6'd13;
			4'd6:    b = 6'd17;
			4'd7:    b = 6'd19;
			4'd8:    b = 6'd23;
			4'd9:    b = 6'd29;
			4'd10:   b = 6'd31;
			4'd11:   b = 6'd37;
			default: b = 6'd2;
		endcase
		return value_t'(b);
	endfunction
endpackage
`default_nettype wire

[src/miller_rabin_primality_test.sv]
// Top level of the deterministic Miller-Rabin primality tester.
// Depends on mrpt_pkg, mrpt_mulmod and assert_macros.svh.
//
//   channel | signals                         | meaning
//   in      | in_valid, in_stall, number      | one value to test
//   out     | out_valid, out_stall, is_prime  | one verdict per request
//
// One request at a time. Each modular product runs through the bit-serial multiplier.
// A base costs at most about 2 * VALUE_WIDTH products, and a prime runs through up
// to 12 bases; most composites finish after the first base. Reset returns the
// controller to idle and empties the output register. A new request is taken
// while a verdict waits.
`default_nettype none
`include "assert_macros.svh"
module miller_rabin_primality_test import mrpt_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   in_valid,
	output logic        in_stall,
	input  wire value_t number,
	output logic        out_valid,
	input  wire logic   out_stall,
	output logic        is_prime
);
	state_t             state_q, state_d;
	value_t             n_q, d_q, e_q, b_q, acc_q;
	logic [RND_W-1:0]   r_q, i_q;
	logic [IDX_W-1:0]   k_q;
	logic               res_q, out_valid_q, out_q;
	logic               mm_start, mm_done;
	value_t             mm_a, mm_b, mm_res, n_m1;

	assign n_m1 = n_q - 1'b1;

	mrpt_mulmod u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mm_start),
		.a      (mm_a),
		.b      (mm_b),
		.m      (n_q),
		.done   (mm_done),
		.result (mm_res)
	);

	always_comb begin
		state_d  = state_q;
		mm_start = 1'b0;
		mm_a     = b_q;
		mm_b     = b_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = (number < value_t'(2)) ? ST_DONE : ST_DECOMP;
				end
			end
			ST_DECOMP: begin
				if (d_q[0]) begin
					state_d = ST_BASE;
				end
			end
			ST_BASE: begin
				state_d = (n_q == base_of(k_q)) ? ST_DONE : ST_REDUCE;
			end
			ST_REDUCE: begin
				if (b_q < n_q) begin
					state_d = ST_POW;
				end
			end
			ST_POW: begin
				if (e_q == '0) begin
					state_d = ST_CHECK;
				end else if (e_q[0]) begin
					mm_start = 1'b1;
					mm_a     = acc_q;
					state_d  = ST_POW_MUL;
				end else begin
					mm_start = 1'b1;
					state_d  = ST_POW_SQ;
				end
			end
			ST_POW_MUL: begin
				if (mm_done) begin
					mm_start = 1'b1;
					state_d  = ST_POW_SQ;
				end
			end
			ST_POW_SQ: begin
				if (mm_done) begin
					state_d = ST_POW;
				end
			end
			ST_CHECK: begin
				if (acc_q == value_t'(1) || acc_q == n_m1) begin
					state_d = (k_q == IDX_W'(BASE_COUNT - 1)) ? ST_DONE : ST_BASE;
				end else begin
					state_d = ST_SQ_LOOP;
				end
			end
			ST_SQ_LOOP: begin
				if (i_q >= r_q) begin
					state_d = ST_DONE;
				end else begin
					mm_start = 1'b1;
					mm_a     = acc_q;
					mm_b     = acc_q;
					state_d  = ST_SQ_WAIT;
				end
			end
			ST_SQ_WAIT: begin
				if (mm_done) begin
					if (mm_res == n_m1) begin
						state_d = (k_q == IDX_W'(BASE_COUNT - 1)) ? ST_DONE : ST_BASE;
					end else begin
						state_d = ST_SQ_LOOP;
					end
				end
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			k_q         <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DONE && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == ST_IDLE) begin
				k_q <= '0;
			end else if (state_d == ST_BASE && state_q != ST_DECOMP) begin
				k_q <= k_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				n_q   <= number;
				d_q   <= number - 1'b1;
				r_q   <= '0;
				res_q <= 1'b0;
			end
			ST_DECOMP: begin
				if (!d_q[0]) begin
					d_q <= d_q >> 1;
					r_q <= r_q + 1'b1;
				end
			end
			ST_BASE: begin
				b_q   <= base_of(k_q);
				res_q <= (n_q == base_of(k_q));
			end
			ST_REDUCE: begin
				if (b_q >= n_q) begin
					b_q <= b_q - n_q;
				end else begin
					acc_q <= value_t'(1);
					e_q   <= d_q;
				end
			end
			ST_POW_MUL: begin
				if (mm_done) begin
					acc_q <= mm_res;
				end
			end
			ST_POW_SQ: begin
				if (mm_done) begin
					b_q <= mm_res;
					e_q <= e_q >> 1;
				end
			end
			ST_CHECK: begin
				i_q   <= RND_W'(1);
				res_q <= 1'b1;
			end
			ST_SQ_LOOP: begin
				if (i_q >= r_q) begin
					res_q <= 1'b0;
				end
			end
			ST_SQ_WAIT: begin
				if (mm_done) begin
					acc_q <= mm_res;
					i_q   <= i_q + 1'b1;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					out_q <= res_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign is_prime  = out_q;

	`AST_IMPLY(a_done_waiting, mm_done,
		state_q == ST_POW_MUL || state_q == ST_POW_SQ || state_q == ST_SQ_WAIT)
	`AST_ALWAYS(a_base_index, k_q < IDX_W'(BASE_COUNT))
	`AST_IMPLY(a_base_reduced, state_q == ST_POW, b_q < n_q)
endmodule
`default_nettype wire

[src/mrpt_mulmod.sv]
// Bit-serial modular multiplier: result = a * b mod m, one bit of b per cycle.
// Depends on mrpt_pkg. Operands must be below m.
`default_nettype none
module mrpt_mulmod import mrpt_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   start,
	input  wire value_t a,
	input  wire value_t b,
	input  wire value_t m,
	output logic        done,
	output value_t      result
);
	value_t                 a_q, b_q, m_q, acc_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   busy_q, done_q;
	logic [VALUE_WIDTH:0]   dbl, sum, mx;
	value_t                 dbl_red, addend, nxt;

	always_comb begin
		mx      = {1'b0, m_q};
		dbl     = {1'b0, acc_q} + {1'b0, acc_q};
		dbl_red = (dbl >= mx) ? VALUE_WIDTH'(dbl - mx) : dbl[VALUE_WIDTH-1:0];
		addend  = b_q[VALUE_WIDTH-1] ? a_q : '0;
		sum     = {1'b0, dbl_red} + {1'b0, addend};
		nxt     = (sum >= mx) ? VALUE_WIDTH'(sum - mx) : sum[VALUE_WIDTH-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(VALUE_WIDTH - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			m_q   <= m;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= nxt;
			b_q   <= {b_q[VALUE_WIDTH-2:0], 1'b0};
		end
	end

	assign done   = done_q;
	assign result = acc_q;
endmodule
`default_nettype wire
